// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the RTL of the page table mapper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check under clock, switched off while reset is held
`define RPTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check under clock, reset included
`define RPTM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/rptm_pkg.sv -----
// Types and constants of the radix page table mapper
package rptm_pkg;

    localparam int unsigned INDEX_BITS = 9;
    localparam int unsigned ENTRIES    = 512;
    localparam int unsigned PPN_SHIFT  = 10;
    localparam int unsigned PAGE_W     = 44;
    localparam int unsigned VPN_W      = 27;
    localparam int unsigned FLAGS_W    = 8;
    localparam int unsigned LEAF_W     = 2;
    localparam int unsigned FIU_W      = 7;
    localparam int unsigned ENTRY_W    = PAGE_W + PPN_SHIFT;

    localparam int unsigned PTE_V_BIT   = 0;
    localparam int unsigned PTE_RWX_LO  = 1;
    localparam int unsigned PTE_RWX_HI  = 3;

    typedef enum logic [1:0] {
        ST_MAPPED      = 2'd0,
        ST_LEAF_IN_WAY = 2'd1,
        ST_EXHAUSTED   = 2'd2,
        ST_OUTSIDE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR = 3'd0,
        S_IDLE  = 3'd1,
        S_READ  = 3'd2,
        S_EVAL  = 3'd3,
        S_LEAF  = 3'd4
    } t_state;

endpackage

// ----- rtl/core/rptm_ram.sv -----
// Generic simple dual-port RAM with registered read
module rptm_ram #(
    parameter int WIDTH = 54,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/radix_page_table_mapper.sv -----
// Top level of the radix page table mapper: walk, allocate and install leaf entries
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------------------
//  request  | in        | start high, busy low      | virtual_page, physical_page,
//           |           |                           | leaf_level, entry_flags
//  result   | out       | o_done, one cycle         | status, leaf_table_page, frames_in_use
//  config   | in        | i_cfg_we                  | i_cfg_wdata (pool_base_page)
//
// Each table level above the leaf passes through S_READ (memory read) and S_EVAL (evaluate, and
// write a newly allocated pointer back through the shared table memory address); the leaf entry
// is written in S_LEAF, and the result strobes in the cycle after it, in which the next transaction
// can already be taken; a failing walk stops early in S_EVAL.
// After reset the table memory is swept to zero, one entry a cycle, over all POOL_FRAMES*512 entries
// (32768 at defaults), with busy high; configuration writes are taken during the sweep.
// The result side has no back-pressure.
`include "assert_macros.svh"

module radix_page_table_mapper #(
    parameter int POOL_FRAMES = 64,
    parameter int LEVELS      = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rptm_pkg::VPN_W-1:0]    i_virtual_page,
    input  logic [rptm_pkg::PAGE_W-1:0]   i_physical_page,
    input  logic [rptm_pkg::LEAF_W-1:0]   i_leaf_level,
    input  logic [rptm_pkg::FLAGS_W-1:0]  i_entry_flags,
    input  logic                          i_cfg_we,
    input  logic [rptm_pkg::PAGE_W-1:0]   i_cfg_wdata,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic [rptm_pkg::PAGE_W-1:0]   o_leaf_table_page,
    output logic [rptm_pkg::FIU_W-1:0]    o_frames_in_use
);

    localparam int DEPTH     = POOL_FRAMES * rptm_pkg::ENTRIES;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int FRAME_W   = $clog2(POOL_FRAMES);
    localparam int CNT_W     = $clog2(POOL_FRAMES + 1);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int VEXT_W    = (rptm_pkg::INDEX_BITS * LEVELS > rptm_pkg::VPN_W) ?
                               rptm_pkg::INDEX_BITS * LEVELS : rptm_pkg::VPN_W;
    localparam int ENTRY_W   = rptm_pkg::ENTRY_W;
    localparam int PAGE_W    = rptm_pkg::PAGE_W;

    rptm_pkg::t_state r_state, n_state;

    logic [LVL_W-1:0]               r_level, n_level;
    logic [LVL_W-1:0]               r_leaf, n_leaf;
    logic [FRAME_W-1:0]             r_frame, n_frame;
    logic [CNT_W-1:0]               r_frames_used, n_frames_used;
    logic [ADDR_W-1:0]              r_clr_addr, n_clr_addr;
    logic [PAGE_W-1:0]              r_base;
    logic [rptm_pkg::VPN_W-1:0]     r_vpn;
    logic [PAGE_W-1:0]              r_ppn;
    logic [rptm_pkg::FLAGS_W-1:0]   r_flags;

    logic                           r_done, n_done;
    rptm_pkg::t_status              r_status, n_status;
    logic [PAGE_W-1:0]              r_tpage, n_tpage;
    logic [rptm_pkg::FIU_W-1:0]     r_fiu, n_fiu;

    logic                           accept;
    logic [LVL_W-1:0]               leaf_clamped;
    logic [VEXT_W-1:0]              vpn_ext;
    logic [rptm_pkg::INDEX_BITS-1:0] walk_index;
    logic [ADDR_W-1:0]              walk_addr;

    logic                           mem_wr_en;
    logic [ADDR_W-1:0]              mem_addr;
    logic [ENTRY_W-1:0]             mem_wr_data;
    logic                           mem_rd_en;
    logic [ENTRY_W-1:0]             mem_rd_data;

    logic                           e_valid;
    logic                           e_rwx;
    logic [PAGE_W-1:0]              e_ptr;
    logic [PAGE_W-1:0]              e_off;
    logic                           off_inside;
    logic                           pool_full;
    logic                           next_is_leaf;
    logic [PAGE_W-1:0]              new_ptr;

    assign accept = start && !busy;
    assign busy   = (r_state != rptm_pkg::S_IDLE);

    always_comb begin
        if (32'(i_leaf_level) > 32'(LEVELS - 1)) begin
            leaf_clamped = LVL_W'(LEVELS - 1);
        end else begin
            leaf_clamped = LVL_W'(i_leaf_level);
        end
    end

    assign vpn_ext    = VEXT_W'(r_vpn);
    assign walk_index = rptm_pkg::INDEX_BITS'(vpn_ext >> (rptm_pkg::INDEX_BITS * r_level));
    assign walk_addr  = ADDR_W'({r_frame, walk_index});

    assign e_valid      = mem_rd_data[rptm_pkg::PTE_V_BIT];
    assign e_rwx        = |mem_rd_data[rptm_pkg::PTE_RWX_HI:rptm_pkg::PTE_RWX_LO];
    assign e_ptr        = mem_rd_data[ENTRY_W-1:rptm_pkg::PPN_SHIFT];
    assign e_off        = e_ptr - r_base;
    assign off_inside   = (e_off < PAGE_W'(POOL_FRAMES));
    assign pool_full    = (r_frames_used >= CNT_W'(POOL_FRAMES));
    assign next_is_leaf = ((r_level - LVL_W'(1)) == r_leaf);
    assign new_ptr      = r_base + PAGE_W'(r_frames_used);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rptm_pkg::S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = rptm_pkg::S_IDLE;
                end
            end
            rptm_pkg::S_IDLE: begin
                if (start) begin
                    if (leaf_clamped == LVL_W'(LEVELS - 1)) begin
                        n_state = rptm_pkg::S_LEAF;
                    end else begin
                        n_state = rptm_pkg::S_READ;
                    end
                end
            end
            rptm_pkg::S_READ: begin
                n_state = rptm_pkg::S_EVAL;
            end
            rptm_pkg::S_EVAL: begin
                priority if (e_valid && e_rwx) begin
                    n_state = rptm_pkg::S_IDLE;
                end else if (e_valid && !off_inside) begin
                    n_state = rptm_pkg::S_IDLE;
                end else if (!e_valid && pool_full) begin
                    n_state = rptm_pkg::S_IDLE;
                end else if (next_is_leaf) begin
                    n_state = rptm_pkg::S_LEAF;
                end else begin
                    n_state = rptm_pkg::S_READ;
                end
            end
            rptm_pkg::S_LEAF: begin
                n_state = rptm_pkg::S_IDLE;
            end
            default: begin
                n_state = rptm_pkg::S_CLEAR;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_level       = r_level;
        n_leaf        = r_leaf;
        n_frame       = r_frame;
        n_frames_used = r_frames_used;
        n_clr_addr    = r_clr_addr;
        n_done        = 1'b0;
        n_status      = r_status;
        n_tpage       = r_tpage;
        n_fiu         = r_fiu;
        mem_wr_en     = 1'b0;
        mem_rd_en     = 1'b0;
        mem_addr      = walk_addr;
        mem_wr_data   = '0;
        unique case (r_state)
            rptm_pkg::S_CLEAR: begin
                mem_wr_en  = 1'b1;
                mem_addr   = r_clr_addr;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
            end
            rptm_pkg::S_IDLE: begin
                if (start) begin
                    n_level = LVL_W'(LEVELS - 1);
                    n_leaf  = leaf_clamped;
                    n_frame = '0;
                end
            end
            rptm_pkg::S_READ: begin
                mem_rd_en = 1'b1;
            end
            rptm_pkg::S_EVAL: begin
                priority if (e_valid && e_rwx) begin
                    n_done   = 1'b1;
                    n_status = rptm_pkg::ST_LEAF_IN_WAY;
                    n_tpage  = '0;
                end else if (e_valid && !off_inside) begin
                    n_done   = 1'b1;
                    n_status = rptm_pkg::ST_OUTSIDE;
                    n_tpage  = '0;
                end else if (e_valid) begin
                    n_frame = FRAME_W'(e_off);
                    n_level = r_level - LVL_W'(1);
                end else if (pool_full) begin
                    n_done   = 1'b1;
                    n_status = rptm_pkg::ST_EXHAUSTED;
                    n_tpage  = '0;
                end else begin
                    mem_wr_en     = 1'b1;
                    mem_wr_data   = {new_ptr, rptm_pkg::PPN_SHIFT'(1)};
                    n_frame       = FRAME_W'(r_frames_used);
                    n_frames_used = r_frames_used + CNT_W'(1);
                    n_level       = r_level - LVL_W'(1);
                end
                n_fiu = rptm_pkg::FIU_W'(r_frames_used);
            end
            rptm_pkg::S_LEAF: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = {r_ppn, rptm_pkg::PPN_SHIFT'(r_flags)}
                            | ENTRY_W'(1);
                n_done      = 1'b1;
                n_status    = rptm_pkg::ST_MAPPED;
                n_tpage     = r_base + PAGE_W'(r_frame);
                n_fiu       = rptm_pkg::FIU_W'(r_frames_used);
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rptm_pkg::S_CLEAR;
            r_clr_addr    <= '0;
            r_frames_used <= CNT_W'(1);
            r_base        <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_frames_used <= n_frames_used;
            r_done        <= n_done;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_level  <= n_level;
        r_leaf   <= n_leaf;
        r_frame  <= n_frame;
        r_status <= n_status;
        r_tpage  <= n_tpage;
        r_fiu    <= n_fiu;
        if (accept) begin
            r_vpn   <= i_virtual_page;
            r_ppn   <= i_physical_page;
            r_flags <= i_entry_flags;
        end
    end

    rptm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_addr),
        .o_rd_data (mem_rd_data)
    );

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_leaf_table_page = r_tpage;
    assign o_frames_in_use   = r_fiu;

    `RPTM_ASSERT(a_frames_bounded, r_frames_used <= CNT_W'(POOL_FRAMES), "frame count beyond pool")
    `RPTM_ASSERT(a_done_single, o_done |=> !o_done, "result strobes in consecutive cycles")
    `RPTM_ASSERT(a_accept_busy, accept |=> busy, "accepted transaction did not raise busy")
    `RPTM_ASSERT(a_write_states, mem_wr_en |-> (r_state == rptm_pkg::S_CLEAR || r_state == rptm_pkg::S_EVAL || r_state == rptm_pkg::S_LEAF), "table write outside a writing state")
    `RPTM_ASSERT(a_no_rw_clash, !(mem_wr_en && mem_rd_en), "table read and write in the same cycle")

endmodule
